// ----- rtl/core/shrf_pkg.sv -----
package shrf_pkg;

  // opcode codes
  localparam logic OP_SHR  = 1'b0;
  localparam logic OP_SHRD = 1'b1;

  // operand size codes for shr; any other code runs at 32 bit
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  localparam int unsigned CNT_W = 5;  // count is masked to five bits

  typedef struct packed {
    logic        opcode;
    logic [1:0]  width_sel;
    logic [31:0] dest_value;
    logic [31:0] fill_value;
    logic [7:0]  shift_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        flags_written;
    logic        carry_flag;
    logic        overflow_written;
    logic        overflow_flag;
    logic        sign_flag;
    logic        zero_flag;
    logic        parity_flag;
  } out_item_t;

endpackage

// ----- rtl/core/shrf_ifs.sv -----
interface shrf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  width_sel;
  logic [31:0] dest_value;
  logic [31:0] fill_value;
  logic [7:0]  shift_count;

  modport source (
    output valid, opcode, width_sel, dest_value, fill_value, shift_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, width_sel, dest_value, fill_value, shift_count,
    output ready
  );
endinterface

interface shrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        flags_written;
  logic        carry_flag;
  logic        overflow_written;
  logic        overflow_flag;
  logic        sign_flag;
  logic        zero_flag;
  logic        parity_flag;

  modport source (
    output valid, result, flags_written, carry_flag, overflow_written,
           overflow_flag, sign_flag, zero_flag, parity_flag,
    input  ready
  );
  modport sink (
    input  valid, result, flags_written, carry_flag, overflow_written,
           overflow_flag, sign_flag, zero_flag, parity_flag,
    output ready
  );
endinterface

// ----- rtl/core/shrf_calc.sv -----
// Barrel shift plus flag reduction, purely combinational.
module shrf_calc import shrf_pkg::*; (
  input  in_item_t  item,
  output out_item_t res
);

  logic [CNT_W-1:0] cnt;
  logic [31:0]      mask;
  logic [4:0]       topbit;
  logic [31:0]      d;
  logic [63:0]      pair;
  logic [31:0]      r;
  logic [CNT_W-1:0] cf_idx;

  always_comb begin
    cnt = item.shift_count[CNT_W-1:0];

    // shrd always runs at 32 bit
    mask   = 32'hffff_ffff;
    topbit = 5'd31;
    if (item.opcode == OP_SHR) begin
      case (item.width_sel)
        WSEL_8: begin
          mask   = 32'h0000_00ff;
          topbit = 5'd7;
        end
        WSEL_16: begin
          mask   = 32'h0000_ffff;
          topbit = 5'd15;
        end
        default: begin
          mask   = 32'hffff_ffff;
          topbit = 5'd31;
        end
      endcase
    end

    d      = item.dest_value & mask;
    // fill bits enter from above; for shr the upper half is zero
    pair   = (item.opcode == OP_SHRD) ? ({item.fill_value, d} >> cnt)
                                      : ({32'd0, d} >> cnt);
    r      = pair[31:0];
    cf_idx = cnt - CNT_W'(1);

    res = '0;
    if (cnt == '0) begin
      res.result = d;
    end else begin
      res.result         = r;
      res.flags_written  = 1'b1;
      res.carry_flag     = d[cf_idx];
      res.sign_flag      = r[topbit];
      res.zero_flag      = ((r & mask) == 32'd0);
      res.parity_flag    = ~^r[7:0];
      if (cnt == CNT_W'(1)) begin
        res.overflow_written = 1'b1;
        res.overflow_flag    = (item.opcode == OP_SHRD) ? (d[31] ^ r[31]) : d[topbit];
      end
    end
  end

endmodule

// ----- rtl/core/x86_shift_right_flags_unit_core.sv -----
// Path: a beat accepted from in_ch passes the input register, then the result register,
//   before it shows at out_ch; a stalled output side can hold it in either register.
// Throughput: one beat per cycle while out_ch.ready is high; set by the two-register pipeline
//   with a single pass of shift and flag logic between them.
// Reset: synchronous, active low; clears both valid bits, payload registers keep data.
module x86_shift_right_flags_unit_core import shrf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  shrf_in_if.sink       in_ch,
  shrf_out_if.source    out_ch
);

  // Stage 1: input register holding the accepted beat.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  in_item_t  in_item;

  // Stage 2: result register facing the output channel.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t calc_res;

  logic      s1_ready;
  logic      s2_ready;

  // Each stage advances when it is empty or its contents move on this cycle,
  // so a full pipeline still takes a new beat every cycle while out_ch.ready is high.
  assign s2_ready = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign in_ch.ready = s1_ready;

  assign in_item.opcode      = in_ch.opcode;
  assign in_item.width_sel   = in_ch.width_sel;
  assign in_item.dest_value  = in_ch.dest_value;
  assign in_item.fill_value  = in_ch.fill_value;
  assign in_item.shift_count = in_ch.shift_count;

  // Shift and flags from the registered beat.
  shrf_calc u_calc (
    .item (s1_item_r),
    .res  (calc_res)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: loaded only on a move, no reset needed.
  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_item_r <= in_item;
    end
    if (s2_ready && s1_valid_r) begin
      out_item_r <= calc_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result           = out_item_r.result;
  assign out_ch.flags_written    = out_item_r.flags_written;
  assign out_ch.carry_flag       = out_item_r.carry_flag;
  assign out_ch.overflow_written = out_item_r.overflow_written;
  assign out_ch.overflow_flag    = out_item_r.overflow_flag;
  assign out_ch.sign_flag        = out_item_r.sign_flag;
  assign out_ch.zero_flag        = out_item_r.zero_flag;
  assign out_ch.parity_flag      = out_item_r.parity_flag;

endmodule

// ----- rtl/core/shrf_chk.sv -----
module shrf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [31:0] out_result,
  input logic        out_flags_written,
  input logic        out_carry_flag,
  input logic        out_overflow_written,
  input logic        out_overflow_flag,
  input logic        out_sign_flag,
  input logic        out_zero_flag,
  input logic        out_parity_flag
);

  // no beat comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // zero count: no flag field may be set
  a_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_flags_written) |->
      (!out_carry_flag && !out_overflow_written && !out_overflow_flag &&
       !out_sign_flag && !out_zero_flag && !out_parity_flag))
    else $error("flag set with zero count");

  // count of one is a nonzero count
  a_ow_implies_fw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow_written) |-> out_flags_written)
    else $error("overflow written without flags");

  a_of_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow_written) |-> !out_overflow_flag)
    else $error("overflow flag without overflow write");

  // result is already at operand width, so ZF matches an all-zero result
  a_zf_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flags_written) |-> (out_zero_flag == (out_result == 32'd0)))
    else $error("zero flag disagrees with result");

endmodule

bind x86_shift_right_flags_unit_core shrf_chk u_shrf_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_result           (out_ch.result),
  .out_flags_written    (out_ch.flags_written),
  .out_carry_flag       (out_ch.carry_flag),
  .out_overflow_written (out_ch.overflow_written),
  .out_overflow_flag    (out_ch.overflow_flag),
  .out_sign_flag        (out_ch.sign_flag),
  .out_zero_flag        (out_ch.zero_flag),
  .out_parity_flag      (out_ch.parity_flag)
);
